>>> src/sst_pkg.sv
// Shared types, codes and constants of the subscriber table.
package sst_pkg;

	localparam int DEF_ENTRIES = 8;

	localparam int CMD_W   = 2;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int TICK_W  = 32;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 7;
	localparam int IVL_W   = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

	localparam logic [TICK_W-1:0] TIMEOUT_RST  = TICK_W'(30 * 1000);
	localparam logic [IVL_W-1:0]  INTERVAL_RST = IVL_W'(25 * 10);

	localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PACKET      = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FRAME       = 2'd3;

	localparam logic [STAT_W-1:0] RS_REFRESHED = 3'd0;
	localparam logic [STAT_W-1:0] RS_ADDED     = 3'd1;
	localparam logic [STAT_W-1:0] RS_REMOVED   = 3'd2;
	localparam logic [STAT_W-1:0] RS_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] RS_NOT_FOUND = 3'd4;
	localparam logic [STAT_W-1:0] RS_DEST      = 3'd5;
	localparam logic [STAT_W-1:0] RS_NOTHING   = 3'd6;
	localparam logic [STAT_W-1:0] RS_EVICTED   = 3'd7;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TICK_W-1:0] seen;
	} entry_t;

	// slot index width, at least one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// width of a counter that can hold n itself
	function automatic int cnt_w(input int n);
		return $clog2(n + 1);
	endfunction

endpackage

>>> src/sst_if.sv
// Stream channels: command input and result output.
interface sst_cmd_if;
	import sst_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [IP_W-1:0]     ip_address;
	logic [PORT_W-1:0]   port_number;
	logic [TICK_W-1:0]   now_ticks;

	modport source(output valid, command, ip_address, port_number, now_ticks, input ready);
	modport sink(input valid, command, ip_address, port_number, now_ticks, output ready);
endinterface

interface sst_res_if;
	import sst_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [IP_W-1:0]     dest_ip;
	logic [PORT_W-1:0]   dest_port;
	logic                last;
	logic [COUNT_W-1:0]  active_count;

	modport source(output valid, status, dest_ip, dest_port, last, active_count, input ready);
	modport sink(input valid, status, dest_ip, dest_port, last, active_count, output ready);
endinterface

>>> src/stream_subscriber_table_with_aging_core.sv
// Top level of the subscriber table with heartbeat aging.
//
//   channel   dir  handshake      payload
//   cmd       in   valid/ready    command, ip_address, port_number, now_ticks
//   result    out  valid/ready    status, dest_ip, dest_port, last, active_count
//   cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// One command at a time; a scan reads one slot of the entry store per cycle unless a held result stalls it.
// A sweep with evictions scans twice (age check, then report).
// Reset clears valid bits, live count and frame phase; entries need no clear pass.
// A held result stalls a scan at the slot that is reporting; a new command
// is taken while the last result still waits in the output register.
module stream_subscriber_table_with_aging_core #(
	parameter int ENTRIES = sst_pkg::DEF_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data,
	sst_cmd_if.sink                         cmd,
	sst_res_if.source                       result
);
	import sst_pkg::*;

	localparam int IDX_W = idx_w(ENTRIES);

	logic              mem_ren;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;

	sst_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.result    (result),
		.mem_ren   (mem_ren),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	sst_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk   (clk),
		.ren   (mem_ren),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

endmodule

>>> src/sst_mem.sv
// Entry store: address, port and heartbeat time per slot, with a registered read.
module sst_mem #(
	parameter int ENTRIES = sst_pkg::DEF_ENTRIES
) (
	input  logic                                clk,
	input  logic                                ren,
	input  logic [sst_pkg::idx_w(ENTRIES)-1:0]  raddr,
	output sst_pkg::entry_t                     rdata,
	input  logic                                we,
	input  logic [sst_pkg::idx_w(ENTRIES)-1:0]  waddr,
	input  sst_pkg::entry_t                     wdata
);
	import sst_pkg::*;

	entry_t mem_q [ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/sst_ctrl.sv
// Sequencer: slot scans, valid bits, aging, config registers and result register.
module sst_ctrl #(
	parameter int ENTRIES = sst_pkg::DEF_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sst_pkg::CFG_DATA_W-1:0]      cfg_data,
	sst_cmd_if.sink                             cmd,
	sst_res_if.source                           result,
	output logic                                mem_ren,
	output logic [sst_pkg::idx_w(ENTRIES)-1:0]  mem_raddr,
	input  sst_pkg::entry_t                     mem_rdata,
	output logic                                mem_we,
	output logic [sst_pkg::idx_w(ENTRIES)-1:0]  mem_waddr,
	output sst_pkg::entry_t                     mem_wdata
);
	import sst_pkg::*;

	localparam int IDX_W = idx_w(ENTRIES);
	localparam int CNT_W = cnt_w(ENTRIES);
	localparam logic [CNT_W-1:0] ENT_N = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] ONE_N = CNT_W'(1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_ONE  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]          state_q;
	logic [TICK_W-1:0]   timeout_q;
	logic [IVL_W-1:0]    interval_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  evict_q;
	logic [CNT_W-1:0]    live_q;
	logic [IVL_W-1:0]    phase_q;

	logic [CMD_W-1:0]    op_q;
	logic [IP_W-1:0]     ip_q;
	logic [PORT_W-1:0]   port_q;
	logic [TICK_W-1:0]   now_q;

	logic [CNT_W-1:0]    iss_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                pend_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [CNT_W-1:0]    emit_cnt_q;
	logic [CNT_W-1:0]    ev_total_q;
	logic [STAT_W-1:0]   one_status_q;

	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [IP_W-1:0]     out_ip_q;
	logic [PORT_W-1:0]   out_port_q;
	logic                out_last_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                load_ok;
	logic                rd_valid;
	logic                rd_evict;
	logic                scanning;
	logic                need_out;
	logic                consume;
	logic                iss_more;
	logic                issue;
	logic                scan_done;
	logic                key_hit;
	logic [TICK_W-1:0]   age;
	logic                stale;
	logic                accept;
	logic [IVL_W:0]      phase_next;
	logic                phase_wrap;
	logic                res_load;
	logic [STAT_W-1:0]   res_status;
	logic [IP_W-1:0]     res_ip;
	logic [PORT_W-1:0]   res_port;
	logic                res_last;
	logic [CNT_W-1:0]    emit_goal;

	assign load_ok  = !out_valid_q || result.ready;
	assign rd_valid = valid_q[idx_s1];
	assign rd_evict = evict_q[idx_s1];
	assign scanning = (state_q == S_SCAN) || (state_q == S_EMIT);
	assign need_out = pend_s1 &&
		(((state_q == S_SCAN) && (op_q == CMD_PACKET) && rd_valid) ||
		 ((state_q == S_EMIT) && rd_evict));
	assign consume   = pend_s1 && (!need_out || load_ok);
	assign iss_more  = iss_q != ENT_N;
	assign issue     = scanning && iss_more && (!pend_s1 || consume);
	assign scan_done = scanning && !iss_more && (!pend_s1 || consume);

	assign key_hit = rd_valid && (mem_rdata.ip == ip_q) && (mem_rdata.port == port_q);
	// wrapping tick difference
	assign age     = now_q - mem_rdata.seen;
	assign stale   = rd_valid && (age > timeout_q);

	assign cmd.ready  = state_q == S_IDLE;
	assign accept     = cmd.valid && cmd.ready;
	assign phase_next = {1'b0, phase_q} + {{IVL_W{1'b0}}, 1'b1};
	assign phase_wrap = phase_next >= {1'b0, interval_q};

	assign mem_ren   = issue;
	assign mem_raddr = iss_q[IDX_W-1:0];
	assign mem_we    = (state_q == S_FIN) && (op_q == CMD_SUBSCRIBE) && (hit_q || free_q);
	assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign mem_wdata = '{ip: ip_q, port: port_q, seen: now_q};

	assign emit_goal = (state_q == S_EMIT) ? ev_total_q : live_q;

	always_comb begin
		res_load   = 1'b0;
		res_status = one_status_q;
		res_ip     = '0;
		res_port   = '0;
		res_last   = 1'b1;
		if (state_q == S_ONE) begin
			res_load = load_ok;
		end else if (need_out && consume) begin
			res_load   = 1'b1;
			res_status = (state_q == S_EMIT) ? RS_EVICTED : RS_DEST;
			res_ip     = mem_rdata.ip;
			res_port   = mem_rdata.port;
			res_last   = (emit_cnt_q + ONE_N) == emit_goal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			timeout_q   <= TIMEOUT_RST;
			interval_q  <= INTERVAL_RST;
			valid_q     <= '0;
			evict_q     <= '0;
			live_q      <= '0;
			phase_q     <= '0;
			iss_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			emit_cnt_q  <= '0;
			ev_total_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TIMEOUT) begin
					timeout_q <= cfg_data;
				end else if (cfg_index == CFG_INTERVAL) begin
					interval_q <= cfg_data[IVL_W-1:0];
				end
			end

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline: slot index issued, data seen in the next cycle
			if (issue) begin
				idx_s1 <= iss_q[IDX_W-1:0];
				iss_q  <= iss_q + ONE_N;
			end
			pend_s1 <= issue || (pend_s1 && !consume);

			if ((state_q == S_SCAN) && consume) begin
				unique case (op_q)
					CMD_SUBSCRIBE: begin
						if (key_hit && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (!rd_valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					CMD_UNSUBSCRIBE: begin
						if (key_hit && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
					end
					CMD_PACKET: begin
						if (rd_valid) begin
							emit_cnt_q <= emit_cnt_q + ONE_N;
						end
					end
					CMD_FRAME: begin
						if (stale) begin
							evict_q[idx_s1] <= 1'b1;
							valid_q[idx_s1] <= 1'b0;
							live_q          <= live_q - ONE_N;
							ev_total_q      <= ev_total_q + ONE_N;
						end
					end
				endcase
			end
			if ((state_q == S_EMIT) && consume && rd_evict) begin
				emit_cnt_q <= emit_cnt_q + ONE_N;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= cmd.command;
						ip_q       <= cmd.ip_address;
						port_q     <= cmd.port_number;
						now_q      <= cmd.now_ticks;
						iss_q      <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						emit_cnt_q <= '0;
						ev_total_q <= '0;
						evict_q    <= '0;
						one_status_q <= RS_NOTHING;
						unique case (cmd.command)
							CMD_SUBSCRIBE: begin
								state_q <= (cmd.port_number == '0) ? S_ONE : S_SCAN;
							end
							CMD_UNSUBSCRIBE: begin
								state_q <= S_SCAN;
							end
							CMD_PACKET: begin
								state_q <= (live_q == '0) ? S_ONE : S_SCAN;
							end
							CMD_FRAME: begin
								if (live_q == '0) begin
									state_q <= S_ONE;
								end else begin
									phase_q <= phase_wrap ? '0 : phase_next[IVL_W-1:0];
									state_q <= (phase_q == '0) ? S_SCAN : S_ONE;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= (op_q == CMD_PACKET) ? S_IDLE : S_FIN;
					end
				end
				S_FIN: begin
					unique case (op_q)
						CMD_SUBSCRIBE: begin
							state_q <= S_ONE;
							if (hit_q) begin
								one_status_q <= RS_REFRESHED;
							end else if (free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								live_q       <= live_q + ONE_N;
								one_status_q <= RS_ADDED;
							end else begin
								one_status_q <= RS_FULL;
							end
						end
						CMD_UNSUBSCRIBE: begin
							state_q <= S_ONE;
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								live_q       <= live_q - ONE_N;
								one_status_q <= RS_REMOVED;
							end else begin
								one_status_q <= RS_NOT_FOUND;
							end
						end
						CMD_FRAME: begin
							if (ev_total_q == '0) begin
								one_status_q <= RS_NOTHING;
								state_q      <= S_ONE;
							end else begin
								iss_q      <= '0;
								emit_cnt_q <= '0;
								state_q    <= S_EMIT;
							end
						end
						CMD_PACKET: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_ONE: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (scan_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q <= res_status;
			out_ip_q     <= res_ip;
			out_port_q   <= res_port;
			out_last_q   <= res_last;
			out_count_q  <= COUNT_W'(live_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.dest_ip      = out_ip_q;
	assign result.dest_port    = out_port_q;
	assign result.last         = out_last_q;
	assign result.active_count = out_count_q;

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= ENT_N)
		else $error("live count above table size");

	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !pend_s1)
		else $error("command taken with a read in flight");

	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_ren)
		else $error("entry write overlaps a scan read");

	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res_status == RS_EVICTED)) |-> (ev_total_q != '0))
		else $error("eviction reported with no eviction counted");

	a_evict_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(evict_q & valid_q) == '0)
		else $error("evicted slot still marked live");
`endif

endmodule
